/* rtl/kpart_pkg.sv */
`timescale 1ns / 1ps
package kpart_pkg;

   localparam int TW        = 7;    // width of totals, part values and part counts
   localparam int RANK_W    = 21;
   localparam int MAX_PARTS = 64;   // most result beats one query may produce
   localparam int ADDR_W    = 6;    // parts memory address, enough for any total up to 127

   typedef struct packed {
      logic [TW-1:0]     total;
      logic [TW-1:0]     part_count;
      logic [RANK_W-1:0] rank;
   } req_type;

   typedef struct packed {
      logic [TW-1:0] part_value;
      logic          found;
      logic          last;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [TW-1:0]     data;
   } ram_wr_type;

endpackage

/* rtl/kth_partition_with_n_parts.sv */
`timescale 1ns / 1ps
// Answers one query at a time: the rank-th (from zero) partition of total into exactly
// part_count parts, partitions taken in descending order with non-increasing parts. The
// block walks every partition of total in that order, holding the parts larger than one
// in a parts memory with a registered read port, and counts the ones with the
// requested number of parts. Each partition visited is counted and then stepped from;
// stepping past a trailing two adds a reread of the previous part when
// other parts above one remain, and shrinking a larger part fills in each copy of
// the new value in the fill state before leaving it. A query's run therefore grows with the
// number of partitions of total up to the chosen one (all of them when the answer is not
// found); the found partition then leaves as part_count beats, largest part first, each
// read, loaded and held until accepted. Queries that are out of range at the door give a
// single not-found beat on the cycle after they are taken. A new query is taken only
// after the last beat of the previous one has been accepted.
module kth_partition_with_n_parts
   import kpart_pkg::*;
#(
   parameter int MAX_TOTAL = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int LIM   = (MAX_TOTAL < 127) ? MAX_TOTAL : 127;
   localparam int DEPTH = LIM / 2;
   localparam int HW    = $clog2(DEPTH + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_ADV   = 4'd2;
   localparam logic [3:0] S_RDW   = 4'd3;
   localparam logic [3:0] S_FILL  = 4'd4;
   localparam logic [3:0] S_ERD   = 4'd5;
   localparam logic [3:0] S_ELD   = 4'd6;
   localparam logic [3:0] S_EWAIT = 4'd7;

   logic [3:0]        state_ff, state_in;
   logic [TW-1:0]     count_ff, count_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [RANK_W-1:0] match_ff, match_in;
   logic [HW-1:0]     h_ff, h_in;       // number of parts above one
   logic [TW-1:0]     m_ff, m_in;       // number of parts
   logic [TW-1:0]     ah_ff, ah_in;     // value of the last part above one
   logic [TW-1:0]     r_ff, r_in;
   logic [TW-1:0]     t_ff, t_in;
   logic [TW-1:0]     k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   ram_wr_type        wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [TW-1:0]     mem_rd;
   logic              req_bad;

   kpart_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr     (wr),
      .rd_addr(rd_addr),
      .rd_data(mem_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_bad = (req_data.total == '0) || (int'(req_data.total) > LIM) ||
                    (req_data.part_count == '0) ||
                    (req_data.part_count > req_data.total) ||
                    (req_data.part_count > TW'(MAX_PARTS));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rank_in      = rank_ff;
      match_in     = match_ff;
      h_in         = h_ff;
      m_in         = m_ff;
      ah_in        = ah_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr           = '0;
      rd_addr      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               count_in = req_data.part_count;
               rank_in  = req_data.rank;
               match_in = '0;
               if (req_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{part_value: '0, found: 1'b0, last: 1'b1};
                  state_in     = S_EWAIT;
               end else begin
                  // first partition is the single part [total]
                  wr.en    = 1'b1;
                  wr.addr  = '0;
                  wr.data  = req_data.total;
                  h_in     = (req_data.total > TW'(1)) ? HW'(1) : '0;
                  m_in     = TW'(1);
                  ah_in    = req_data.total;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (m_ff == count_ff && match_ff == rank_ff) begin
               k_in     = '0;
               state_in = S_ERD;
            end else begin
               if (m_ff == count_ff) begin
                  match_in = match_ff + RANK_W'(1);
               end
               if (h_ff == '0) begin
                  // all ones reached, walk is over
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{part_value: '0, found: 1'b0, last: 1'b1};
                  state_in     = S_EWAIT;
               end else begin
                  state_in = S_ADV;
               end
            end
         end
         S_ADV: begin
            if (ah_ff == TW'(2)) begin
               // last big part drops to one
               m_in = m_ff + TW'(1);
               h_in = h_ff - HW'(1);
               if (h_ff > HW'(1)) begin
                  rd_addr  = ADDR_W'(h_ff - HW'(2));
                  state_in = S_RDW;
               end else begin
                  state_in = S_CHECK;
               end
            end else begin
               r_in     = ah_ff - TW'(1);
               t_in     = m_ff - TW'(h_ff) + TW'(1);
               wr.en    = 1'b1;
               wr.addr  = ADDR_W'(h_ff - HW'(1));
               wr.data  = ah_ff - TW'(1);
               ah_in    = ah_ff - TW'(1);
               state_in = S_FILL;
            end
         end
         S_RDW: begin
            ah_in    = mem_rd;
            state_in = S_CHECK;
         end
         S_FILL: begin
            if (t_ff >= r_ff) begin
               h_in    = h_ff + HW'(1);
               wr.en   = 1'b1;
               wr.addr = ADDR_W'(h_ff);
               wr.data = r_ff;
               t_in    = t_ff - r_ff;
            end else begin
               m_in = (t_ff == '0) ? TW'(h_ff) : TW'(h_ff) + TW'(1);
               if (t_ff > TW'(1)) begin
                  h_in    = h_ff + HW'(1);
                  wr.en   = 1'b1;
                  wr.addr = ADDR_W'(h_ff);
                  wr.data = t_ff;
                  ah_in   = t_ff;
               end
               state_in = S_CHECK;
            end
         end
         S_ERD: begin
            rd_addr  = ADDR_W'(k_ff);
            state_in = S_ELD;
         end
         S_ELD: begin
            // positions past the big parts are implicit ones
            rsp_data_in.part_value = (TW'(h_ff) > k_ff) ? mem_rd : TW'(1);
            rsp_data_in.found      = 1'b1;
            rsp_data_in.last       = (k_ff + TW'(1) == count_ff);
            rsp_valid_in           = 1'b1;
            state_in               = S_EWAIT;
         end
         S_EWAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_data_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + TW'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         h_ff         <= '0;
         m_ff         <= '0;
         match_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         h_ff         <= h_in;
         m_ff         <= m_in;
         match_ff     <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      rank_ff     <= rank_in;
      ah_ff       <= ah_in;
      r_ff        <= r_in;
      t_ff        <= t_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("query accepted while a result beat is pending");

   a_miss_is_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |->
         (rsp_data_ff.last && rsp_data_ff.part_value == '0))
      else $error("not-found beat must be a single zero last beat");

   a_wait_has_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EWAIT) |-> rsp_valid_ff)
      else $error("waiting for result accept with no beat held");

   a_h_in_range: assert property (@(posedge clock) disable iff (reset)
      h_ff <= HW'(DEPTH))
      else $error("big part count beyond parts memory depth");

endmodule

/* rtl/kpart_ram.sv */
`timescale 1ns / 1ps
module kpart_ram
   import kpart_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic              clock,
   input  ram_wr_type        wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [TW-1:0]     rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [TW-1:0] mem [DEPTH];
   logic [TW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/sv/kth_partition_with_n_parts_test.sv */
`timescale 1ns / 1ps
module kth_partition_with_n_parts_test;
   import kpart_pkg::*;

   localparam int TOTAL_LIM   = 64;
   localparam int UNSEEN_LIM  = 400000;
   localparam int SETTLE_CYC  = 20;
   localparam int unsigned WAYS_CAP = 32'd1 << 22;
   localparam logic [RANK_W-1:0] RANK_ALL = '1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // part_ways[m][j][p]: partitions of m into exactly j parts, none above p
   int unsigned part_ways [0:TOTAL_LIM][0:TOTAL_LIM][0:TOTAL_LIM];
   rsp_type     partition_beats[$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   kth_partition_with_n_parts #(.MAX_TOTAL(TOTAL_LIM)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void fill_partition_table();
      int unsigned v;
      for (int p = 0; p <= TOTAL_LIM; p++) begin
         for (int m = 0; m <= TOTAL_LIM; m++) begin
            for (int j = 0; j <= TOTAL_LIM; j++) begin
               if (m == 0 || j == 0) begin
                  v = (m == 0 && j == 0) ? 1 : 0;
               end else if (p == 0) begin
                  v = 0;
               end else begin
                  v = part_ways[m][j][p-1];
                  if (m >= p) v += part_ways[m-p][j-1][p];
                  if (v > WAYS_CAP) v = WAYS_CAP;
               end
               part_ways[m][j][p] = v;
            end
         end
      end
   endfunction

   function automatic int unsigned matching_count(int unsigned t, int unsigned c);
      if (t == 0 || t > TOTAL_LIM || c == 0 || c > t) return 0;
      return part_ways[t][c][t];
   endfunction

   // picks the parts of the requested partition largest first and queues the beats, or queues a single not-found beat
   task automatic choose_partition(input req_type q);
      int unsigned total_v, count_v, rank_v, remaining, left, cap, a, pick, c;
      rsp_type     beat;
      total_v = q.total;
      count_v = q.part_count;
      rank_v  = q.rank;
      if (total_v == 0 || total_v > TOTAL_LIM || count_v == 0 || count_v > total_v ||
          count_v > MAX_PARTS || part_ways[total_v][count_v][total_v] <= rank_v) begin
         beat.part_value = '0;
         beat.found = 1'b0;
         beat.last = 1'b1;
         partition_beats.push_back(beat);
         return;
      end
      remaining = total_v;
      left = count_v;
      cap = total_v;
      for (int pos = 0; pos < count_v; pos++) begin
         a = remaining - (left - 1);
         if (a > cap) a = cap;
         pick = 1;
         for (; a >= 1; a--) begin
            c = part_ways[remaining-a][left-1][a];
            if (rank_v < c) begin
               pick = a;
               break;
            end
            rank_v -= c;
         end
         beat.part_value = pick[TW-1:0];
         beat.found = 1'b1;
         beat.last = (pos == count_v - 1);
         partition_beats.push_back(beat);
         remaining -= pick;
         cap = pick;
         left--;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (partition_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat part_value=%0d found=%0b last=%0b",
                                      rsp_data.part_value, rsp_data.found, rsp_data.last));
         end else begin
            want = partition_beats.pop_front();
            if (rsp_data.part_value !== want.part_value)
               report_mismatch($sformatf("part_value %0d, expected %0d",
                                         rsp_data.part_value, want.part_value));
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %0b, expected %0b", rsp_data.found, want.found));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b", rsp_data.last, want.last));
         end
      end
   end

   // receiver: long hold-off when asked, otherwise random idling
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= UNSEEN_LIM) begin
            $display("stalled for %0d cycles with beats outstanding", quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_query(input logic [TW-1:0] t, input logic [TW-1:0] c,
                             input logic [RANK_W-1:0] r);
      int      gap;
      req_type q;
      q.total = t;
      q.part_count = c;
      q.rank = r;
      gap = 0;
      while (gap < 10 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      choose_partition(q);
   endtask

   task automatic stop_sending();
      @(negedge clock) req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (partition_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // mostly well-formed queries on small totals; the rest out of range or past the end
   task automatic send_random_query();
      int unsigned t, c, n;
      int          sel;
      logic [RANK_W-1:0] r;
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
         t = (sel < 70) ? $urandom_range(1, 16) : $urandom_range(17, 26);
         c = $urandom_range(1, t);
         n = matching_count(t, c);
         r = ($urandom_range(0, 3) == 0) ? RANK_W'(n - 1) : RANK_W'($urandom_range(0, n - 1));
      end else if (sel < 85) begin
         t = $urandom_range(1, 16);
         c = $urandom_range(1, t);
         r = RANK_W'(matching_count(t, c));
      end else begin
         case ($urandom_range(0, 2))
            0: t = 0;
            1: t = $urandom_range(TOTAL_LIM + 1, 127);
            default: t = $urandom_range(1, 16);
         endcase
         c = $urandom_range(0, 127);
         r = RANK_W'($urandom);
      end
      send_query(t[TW-1:0], c[TW-1:0], r);
   endtask

   task automatic test_edge_queries();
      send_query(7'd1, 7'd1, '0);
      send_query(7'd7, 7'd1, '0);                 // whole total as one part is counted
      send_query(7'd7, 7'd1, 21'd1);
      send_query(7'd64, 7'd1, '0);
      send_query(7'd64, 7'd2, '0);
      send_query(7'd64, 7'd2, 21'd1);
      send_query(7'd0, 7'd1, '0);
      send_query(7'd0, 7'd0, '0);
      send_query(7'd65, 7'd1, '0);
      send_query(7'd127, 7'd127, RANK_ALL);
      send_query(7'd64, 7'd0, '0);
      send_query(7'd5, 7'd6, '0);
      send_query(7'd20, 7'd65, '0);
      send_query(7'd9, 7'd9, '0);
      send_query(7'd12, 7'd4, RANK_W'(matching_count(12, 4) - 1));
      send_query(7'd12, 7'd4, RANK_W'(matching_count(12, 4)));
      send_query(7'd10, 7'd3, RANK_ALL);
      send_query(7'd15, 7'd5, 21'd3);
      send_query(7'd20, 7'd20, '0);
      send_query(7'd16, 7'd8, RANK_W'(matching_count(16, 8) / 2));
      send_query(7'd18, 7'd1, '0);
      stop_sending();
   endtask

   task automatic test_random_queries(input int send_pct, input int recv_pct, input int n);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (n) send_random_query();
      stop_sending();
   endtask

   // result side held off while more queries wait at the input
   task automatic test_output_stall();
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock) hold_left = 300;
      send_query(7'd6, 7'd3, '0);
      send_query(7'd8, 7'd4, 21'd2);
      send_query(7'd11, 7'd5, 21'd1);
      send_query(7'd3, 7'd3, '0);
      stop_sending();
   endtask

   initial begin
      fill_partition_table();
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);
      test_edge_queries();
      test_random_queries(31, 56, 25);
      test_random_queries(56, 31, 25);
      test_random_queries(0, 0, 25);
      test_output_stall();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
